// File: src/wfs_pkg.sv
// ----------------------------------------------------------------------------
// wfs_pkg
// shared constants for the wall-follow steering block
// ----------------------------------------------------------------------------
package wfs_pkg;

  // configuration port
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  // register indexes
  localparam logic [CfgIdxBits-1:0] CFG_STEER_ENABLE  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_CHANGE_THRESH = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_LEFT_THRESH   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_RIGHT_THRESH  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_LEFT_BASE     = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_RIGHT_BASE    = 3'd5;
  localparam logic [CfgIdxBits-1:0] CFG_STEER_GAIN    = 3'd6;

  // field widths that do not follow the sensor width
  localparam int unsigned ChgThrBits = 12;
  localparam int unsigned PrescBits  = 16;
  localparam int unsigned GainBits   = 16;

  // threshold raise on a large change
  localparam int unsigned ThreshRaise = 10;

  // gain after reset, about 0.005 in Q0.16
  localparam logic [GainBits-1:0] GAIN_RESET = 16'd328;

endpackage

// File: src/wfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// wfs_cfg_regs
// configuration register file, one write port, index decode
// ----------------------------------------------------------------------------
module wfs_cfg_regs
  import wfs_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [CfgIdxBits-1:0]  wr_index_i,
  input  logic [CfgDataBits-1:0] wr_data_i,
  output logic                   steer_enable_o,
  output logic [ChgThrBits-1:0]  change_threshold_o,
  output logic [SENSOR_BITS-1:0] left_wall_threshold_o,
  output logic [SENSOR_BITS-1:0] right_wall_threshold_o,
  output logic [PrescBits-1:0]   left_base_prescaler_o,
  output logic [PrescBits-1:0]   right_base_prescaler_o,
  output logic [GainBits-1:0]    steer_gain_o
);

  logic                   enable_q;
  logic [ChgThrBits-1:0]  chg_thr_q;
  logic [SENSOR_BITS-1:0] left_thr_q;
  logic [SENSOR_BITS-1:0] right_thr_q;
  logic [PrescBits-1:0]   left_base_q;
  logic [PrescBits-1:0]   right_base_q;
  logic [GainBits-1:0]    gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      chg_thr_q    <= '0;
      left_thr_q   <= '0;
      right_thr_q  <= '0;
      left_base_q  <= '0;
      right_base_q <= '0;
      gain_q       <= GAIN_RESET;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_STEER_ENABLE:  enable_q     <= wr_data_i[0];
        CFG_CHANGE_THRESH: chg_thr_q    <= wr_data_i[ChgThrBits-1:0];
        CFG_LEFT_THRESH:   left_thr_q   <= wr_data_i[SENSOR_BITS-1:0];
        CFG_RIGHT_THRESH:  right_thr_q  <= wr_data_i[SENSOR_BITS-1:0];
        CFG_LEFT_BASE:     left_base_q  <= wr_data_i[PrescBits-1:0];
        CFG_RIGHT_BASE:    right_base_q <= wr_data_i[PrescBits-1:0];
        CFG_STEER_GAIN:    gain_q       <= wr_data_i[GainBits-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign steer_enable_o         = enable_q;
  assign change_threshold_o     = chg_thr_q;
  assign left_wall_threshold_o  = left_thr_q;
  assign right_wall_threshold_o = right_thr_q;
  assign left_base_prescaler_o  = left_base_q;
  assign right_base_prescaler_o = right_base_q;
  assign steer_gain_o           = gain_q;

endmodule

// File: src/wall_follow_steering_top.sv
// ----------------------------------------------------------------------------
// wall_follow_steering_top
// wall-following steering error and motor prescaler correction
// ----------------------------------------------------------------------------
// usage:
//   input channel: one transfer per control tick with both sensor levels and
//   level changes; accepted when in_valid_i is high and in_stall_o is low
//   output channel: steering error plus new left and right prescalers;
//   taken when out_valid_o is high and out_stall_i is low
//   config channel: cfg_valid_i/cfg_ready_o write of one register by index,
//   always ready; write only while no tick is in flight
// latency: five cycles from input transfer to out_valid_o (flag compare,
//   wall case and error, gain multiply, rounding, saturating add)
// throughput: one tick per cycle, set by the five-stage pipeline with no
//   stage looping; the gain multiplier is the deepest stage
// stall: each stage holds while the one after it is full and stalled, so a
//   stalled output stops the pipe from the back without losing a tick;
//   in_stall_o rises only once every stage holds a tick
// disabled: a tick taken while steer_enable is 0 enters with its valid bit
//   cleared and never shows on the output
// reset: pipeline emptied, registers cleared, gain back to its default
// ----------------------------------------------------------------------------
module wall_follow_steering_top
  import wfs_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SENSOR_BITS-1:0] left_level_i,
  input  logic [SENSOR_BITS-1:0] right_level_i,
  input  logic signed [SENSOR_BITS:0] left_change_i,
  input  logic signed [SENSOR_BITS:0] right_change_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [SENSOR_BITS+1:0] steer_error_o,
  output logic [PrescBits-1:0]   left_prescaler_o,
  output logic [PrescBits-1:0]   right_prescaler_o
);

  // widths
  localparam int unsigned ChgW  = SENSOR_BITS + 1;          // change field
  localparam int unsigned ErrW  = SENSOR_BITS + 2;          // error field
  localparam int unsigned WideW = SENSOR_BITS + 3;          // error before clamp
  localparam int unsigned AbsW  = (ChgW > ChgThrBits) ? ChgW : ChgThrBits;
  localparam int unsigned ProdW = ErrW + GainBits + 1;      // signed product
  localparam int unsigned CorrW = ProdW - GainBits;         // product >> 16
  localparam int unsigned SumW  = ((CorrW > PrescBits + 1) ? CorrW : PrescBits + 1) + 1;
  localparam logic [SENSOR_BITS:0] RAISE = (SENSOR_BITS + 1)'(ThreshRaise);
  localparam logic [ProdW-1:0] ROUND_BIAS = ProdW'({GainBits{1'b1}});

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                   steer_enable;
  logic [ChgThrBits-1:0]  change_threshold;
  logic [SENSOR_BITS-1:0] left_wall_threshold;
  logic [SENSOR_BITS-1:0] right_wall_threshold;
  logic [PrescBits-1:0]   left_base_prescaler;
  logic [PrescBits-1:0]   right_base_prescaler;
  logic [GainBits-1:0]    steer_gain;

  assign cfg_ready_o = 1'b1;

  wfs_cfg_regs #(
    .SENSOR_BITS(SENSOR_BITS)
  ) u_cfg_regs (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .wr_en_i               (cfg_valid_i & cfg_ready_o),
    .wr_index_i            (cfg_index_i),
    .wr_data_i             (cfg_data_i),
    .steer_enable_o        (steer_enable),
    .change_threshold_o    (change_threshold),
    .left_wall_threshold_o (left_wall_threshold),
    .right_wall_threshold_o(right_wall_threshold),
    .left_base_prescaler_o (left_base_prescaler),
    .right_base_prescaler_o(right_base_prescaler),
    .steer_gain_o          (steer_gain)
  );

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage moves when it is empty or the next moves
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic s1_adv, s2_adv, s3_adv, s4_adv, s5_adv;

  assign s5_adv = !s5_valid_q || !out_stall_i;
  assign s4_adv = !s4_valid_q || s5_adv;
  assign s3_adv = !s3_valid_q || s4_adv;
  assign s2_adv = !s2_valid_q || s3_adv;
  assign s1_adv = !s1_valid_q || s2_adv;

  assign in_stall_o = !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      // ticks taken while disabled get no valid bit
      if (s1_adv) s1_valid_q <= in_valid_i & steer_enable;
      if (s2_adv) s2_valid_q <= s1_valid_q;
      if (s3_adv) s3_valid_q <= s2_valid_q;
      if (s4_adv) s4_valid_q <= s3_valid_q;
      if (s5_adv) s5_valid_q <= s4_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: absolute change against the change threshold
  // --------------------------------------------------------------------------
  logic [ChgW-1:0] l_abs, r_abs;
  logic            l_raise_d, r_raise_d;

  logic [SENSOR_BITS-1:0] s1_l_lvl_q, s1_r_lvl_q;
  logic signed [ChgW-1:0] s1_l_chg_q, s1_r_chg_q;
  logic                   s1_l_raise_q, s1_r_raise_q;

  // the most negative change wraps to 2^SENSOR_BITS, read as unsigned
  assign l_abs = left_change_i[ChgW-1]  ? ChgW'(-left_change_i)  : left_change_i;
  assign r_abs = right_change_i[ChgW-1] ? ChgW'(-right_change_i) : right_change_i;

  assign l_raise_d = AbsW'(l_abs) >= AbsW'(change_threshold);
  assign r_raise_d = AbsW'(r_abs) >= AbsW'(change_threshold);

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_l_lvl_q   <= left_level_i;
      s1_r_lvl_q   <= right_level_i;
      s1_l_chg_q   <= left_change_i;
      s1_r_chg_q   <= right_change_i;
      s1_l_raise_q <= l_raise_d;
      s1_r_raise_q <= r_raise_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: wall detection, case selection, error clamp
  // --------------------------------------------------------------------------
  logic [SENSOR_BITS:0]    l_thr, r_thr, l_lvl_x, r_lvl_x;
  logic                    l_ge, l_le, r_ge, r_le;
  logic signed [WideW-1:0] l_chg_x, r_chg_x, err_wide;
  logic signed [ErrW-1:0]  err_d;
  logic signed [ErrW-1:0]  s2_err_q;

  assign l_thr   = {1'b0, left_wall_threshold}  + (s1_l_raise_q ? RAISE : '0);
  assign r_thr   = {1'b0, right_wall_threshold} + (s1_r_raise_q ? RAISE : '0);
  assign l_lvl_x = {1'b0, s1_l_lvl_q};
  assign r_lvl_x = {1'b0, s1_r_lvl_q};

  assign l_ge = l_lvl_x >= l_thr;
  assign l_le = l_lvl_x <= l_thr;
  assign r_ge = r_lvl_x >= r_thr;
  assign r_le = r_lvl_x <= r_thr;

  assign l_chg_x = WideW'(s1_l_chg_q);
  assign r_chg_x = WideW'(s1_r_chg_q);

  always_comb begin
    if (l_ge && r_ge) begin
      err_wide = l_chg_x - r_chg_x;            // both walls
    end else if (l_le && r_le) begin
      err_wide = '0;                           // no wall
    end else if (r_ge) begin
      err_wide = -(r_chg_x <<< 1);             // right wall only
    end else begin
      err_wide = l_chg_x <<< 1;                // left wall only
    end
  end

  // clamp to the error field when the top two bits disagree
  assign err_d = (err_wide[WideW-1] != err_wide[WideW-2])
               ? {err_wide[WideW-1], {(ErrW-1){~err_wide[WideW-1]}}}
               : err_wide[ErrW-1:0];

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      s2_err_q <= err_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: gain multiply
  // --------------------------------------------------------------------------
  logic signed [ProdW-1:0] prod_d, s3_prod_q;
  logic signed [ErrW-1:0]  s3_err_q;

  assign prod_d = ProdW'(s2_err_q) * ProdW'($signed({1'b0, steer_gain}));

  always_ff @(posedge clk_i) begin
    if (s3_adv && s2_valid_q) begin
      s3_prod_q <= prod_d;
      s3_err_q  <= s2_err_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: drop the fraction, rounding toward zero
  // --------------------------------------------------------------------------
  logic [ProdW-1:0]        biased;
  logic signed [CorrW-1:0] s4_corr_q;
  logic signed [ErrW-1:0]  s4_err_q;

  assign biased = s3_prod_q + (s3_prod_q[ProdW-1] ? ROUND_BIAS : '0);

  always_ff @(posedge clk_i) begin
    if (s4_adv && s3_valid_q) begin
      s4_corr_q <= biased[ProdW-1:GainBits];
      s4_err_q  <= s3_err_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: apply correction, saturate, output register
  // --------------------------------------------------------------------------
  logic signed [SumW-1:0]  corr_x, l_base_x, r_base_x, l_sum, r_sum;
  logic [PrescBits-1:0]    l_sat, r_sat;
  logic signed [ErrW-1:0]  s5_err_q;
  logic [PrescBits-1:0]    s5_left_q, s5_right_q;

  assign corr_x   = SumW'(s4_corr_q);
  assign l_base_x = $signed({{(SumW-PrescBits){1'b0}}, left_base_prescaler});
  assign r_base_x = $signed({{(SumW-PrescBits){1'b0}}, right_base_prescaler});
  assign l_sum    = l_base_x - corr_x;
  assign r_sum    = r_base_x + corr_x;

  always_comb begin
    if (l_sum[SumW-1]) begin
      l_sat = '0;
    end else if (|l_sum[SumW-2:PrescBits]) begin
      l_sat = '1;
    end else begin
      l_sat = l_sum[PrescBits-1:0];
    end
    if (r_sum[SumW-1]) begin
      r_sat = '0;
    end else if (|r_sum[SumW-2:PrescBits]) begin
      r_sat = '1;
    end else begin
      r_sat = r_sum[PrescBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_adv && s4_valid_q) begin
      s5_err_q   <= s4_err_q;
      s5_left_q  <= l_sat;
      s5_right_q <= r_sat;
    end
  end

  assign out_valid_o       = s5_valid_q;
  assign steer_error_o     = s5_err_q;
  assign left_prescaler_o  = s5_left_q;
  assign right_prescaler_o = s5_right_q;

endmodule

// File: src/wfs_checker.sv
// ----------------------------------------------------------------------------
// wfs_checker
// port-level checks for the wall-follow steering block
// ----------------------------------------------------------------------------
module wfs_checker
  import wfs_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CfgIdxBits-1:0]  cfg_index_i,
  input logic [CfgDataBits-1:0] cfg_data_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [SENSOR_BITS+1:0] steer_error_o,
  input logic [PrescBits-1:0]   left_prescaler_o,
  input logic [PrescBits-1:0]   right_prescaler_o
);

  // shadow of the base prescalers as seen on the config port
  logic [PrescBits-1:0] left_base_q, right_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_base_q  <= '0;
      right_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_LEFT_BASE)  left_base_q  <= cfg_data_i[PrescBits-1:0];
      if (cfg_index_i == CFG_RIGHT_BASE) right_base_q <= cfg_data_i[PrescBits-1:0];
    end
  end

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(steer_error_o)
      && $stable(left_prescaler_o) && $stable(right_prescaler_o))
    else $error("stalled result changed");

  // the input side only backs up behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // zero error leaves both prescalers at their bases
  a_zero_error_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (steer_error_o == '0) |->
      (left_prescaler_o == left_base_q) && (right_prescaler_o == right_base_q))
    else $error("zero error changed a prescaler");

  // config port never pushes back
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind wall_follow_steering_top wfs_checker #(
  .SENSOR_BITS(SENSOR_BITS)
) u_wfs_checker (.*);

// File: test/wall_follow_steering_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wall_follow_steering_top_tb
// self-checking bench for the wall-follow steering block
// ----------------------------------------------------------------------------
// A short table of directed ticks and register writes runs first. It covers
// the field extremes, the four wall cases, level ties at the threshold, error
// saturation, prescaler clamping, disabled ticks and a write to an unused
// index. Random phases follow. Each phase first writes a fresh register
// setting while the block is idle, then sends random ticks whose levels
// cluster around the wall thresholds and whose changes cluster around the
// change threshold. A local steering model predicts every result not typed
// into the table. Both channels idle at random, and one phase holds the
// output off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module wall_follow_steering_top_tb;
  import wfs_pkg::*;

  localparam int SENSOR_BITS = 12;
  localparam int CLK_PERIOD  = 8;

  // field ranges at this sensor width
  localparam int LEVEL_MAX = (1 << SENSOR_BITS) - 1;
  localparam int CHG_MIN   = -(1 << SENSOR_BITS);
  localparam int CHG_MAX   = (1 << SENSOR_BITS) - 1;
  localparam int ERR_MAX   = (1 << (SENSOR_BITS + 1)) - 1;
  localparam int ERR_MIN   = -ERR_MAX - 1;
  localparam int PRESC_MAX = (1 << PrescBits) - 1;
  localparam int RAISE     = int'(ThreshRaise);

  // index past the last register, must be ignored by the block
  localparam logic [CfgIdxBits-1:0] CFG_UNUSED_IDX = 3'd7;

  // run shape
  localparam int NUM_PHASES      = 12;
  localparam int TICKS_PER_PHASE = 140;
  localparam int PRESSURE_PHASE  = 3;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 12;  // pipeline depth plus margin
  localparam int FINAL_WAIT      = 5000;
  localparam int MAX_REPORTS     = 10;
  localparam int RUN_LIMIT_NS    = 8_000_000;

  typedef struct packed {
    logic [SENSOR_BITS-1:0]     ll;
    logic [SENSOR_BITS-1:0]     rl;
    logic signed [SENSOR_BITS:0] lc;
    logic signed [SENSOR_BITS:0] rc;
  } tick_t;

  typedef struct packed {
    logic signed [SENSOR_BITS+1:0] err;
    logic [PrescBits-1:0]          lp;
    logic [PrescBits-1:0]          rp;
  } steer_res_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] data;
    tick_t                  tick;
    bit                     typed;   // expectation written into the row
    steer_res_t             res;
  } dir_row_t;

  // dut ports, all inputs known from time zero
  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_valid_i    = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIdxBits-1:0]       cfg_index_i    = '0;
  logic [CfgDataBits-1:0]      cfg_data_i     = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic [SENSOR_BITS-1:0]      left_level_i   = '0;
  logic [SENSOR_BITS-1:0]      right_level_i  = '0;
  logic signed [SENSOR_BITS:0] left_change_i  = '0;
  logic signed [SENSOR_BITS:0] right_change_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic signed [SENSOR_BITS+1:0] steer_error_o;
  logic [PrescBits-1:0]        left_prescaler_o;
  logic [PrescBits-1:0]        right_prescaler_o;

  // register shadow, kept in step with every completed write
  int cfg_enable   = 0;
  int cfg_chg_thr  = 0;
  int cfg_left_thr = 0;
  int cfg_right_thr = 0;
  int cfg_left_base = 0;
  int cfg_right_base = 0;
  int cfg_gain     = int'(GAIN_RESET);

  steer_res_t steer_due[$];   // predicted results, oldest first
  int         fault_count  = 0;
  int         result_count = 0;
  bit         hold_off_req = 1'b0;

  wall_follow_steering_top #(
    .SENSOR_BITS(SENSOR_BITS)
  ) dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // steering model
  // --------------------------------------------------------------------------

  function automatic longint clamp_presc(input longint v);
    if (v < 0) return 0;
    if (v > PRESC_MAX) return PRESC_MAX;
    return v;
  endfunction

  // returns 0 when the tick yields no result (steering disabled)
  function automatic bit predict_steer(input tick_t t, output steer_res_t r);
    int     l_lvl, r_lvl, l_chg, r_chg, l_th, r_th, err;
    longint corr, lp, rp;
    r = '0;
    if (cfg_enable == 0) return 1'b0;
    l_lvl = int'(t.ll);
    r_lvl = int'(t.rl);
    l_chg = int'($signed(t.lc));
    r_chg = int'($signed(t.rc));
    // threshold goes up by the raise when the change is large
    l_th = cfg_left_thr + ((((l_chg < 0) ? -l_chg : l_chg) >= cfg_chg_thr) ? RAISE : 0);
    r_th = cfg_right_thr + ((((r_chg < 0) ? -r_chg : r_chg) >= cfg_chg_thr) ? RAISE : 0);
    // wall cases, order matters for ties at the threshold
    if (l_lvl >= l_th && r_lvl >= r_th) err = l_chg - r_chg;
    else if (l_lvl <= l_th && r_lvl <= r_th) err = 0;
    else if (r_lvl >= r_th) err = -2 * r_chg;
    else err = 2 * l_chg;
    if (err > ERR_MAX) err = ERR_MAX;
    if (err < ERR_MIN) err = ERR_MIN;
    // integer division truncates toward zero, as the gain product must
    corr = (longint'(err) * longint'(cfg_gain)) / 65536;
    lp = clamp_presc(longint'(cfg_left_base) - corr);
    rp = clamp_presc(longint'(cfg_right_base) + corr);
    r.err = err[SENSOR_BITS+1:0];
    r.lp  = lp[PrescBits-1:0];
    r.rp  = rp[PrescBits-1:0];
    return 1'b1;
  endfunction

  function automatic void apply_cfg(input logic [CfgIdxBits-1:0] idx,
                                    input logic [CfgDataBits-1:0] val);
    case (idx)
      CFG_STEER_ENABLE:  cfg_enable     = int'(val[0]);
      CFG_CHANGE_THRESH: cfg_chg_thr    = int'(val[ChgThrBits-1:0]);
      CFG_LEFT_THRESH:   cfg_left_thr   = int'(val[SENSOR_BITS-1:0]);
      CFG_RIGHT_THRESH:  cfg_right_thr  = int'(val[SENSOR_BITS-1:0]);
      CFG_LEFT_BASE:     cfg_left_base  = int'(val[PrescBits-1:0]);
      CFG_RIGHT_BASE:    cfg_right_base = int'(val[PrescBits-1:0]);
      CFG_STEER_GAIN:    cfg_gain       = int'(val[GainBits-1:0]);
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic dir_row_t cfg_row(input logic [CfgIdxBits-1:0] idx, input int val);
    dir_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.data  = val[CfgDataBits-1:0];
    row.tick  = '0;
    row.typed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  function automatic dir_row_t tick_row(input int ll, input int rl, input int lc, input int rc);
    dir_row_t row;
    row.kind    = ROW_TICK;
    row.idx     = '0;
    row.data    = '0;
    row.tick.ll = ll[SENSOR_BITS-1:0];
    row.tick.rl = rl[SENSOR_BITS-1:0];
    row.tick.lc = lc[SENSOR_BITS:0];
    row.tick.rc = rc[SENSOR_BITS:0];
    row.typed   = 1'b0;
    row.res     = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(input int ll, input int rl, input int lc, input int rc,
                                         input int err, input int lp, input int rp);
    dir_row_t row;
    row        = tick_row(ll, rl, lc, rc);
    row.typed  = 1'b1;
    row.res.err = err[SENSOR_BITS+1:0];
    row.res.lp  = lp[PrescBits-1:0];
    row.res.rp  = rp[PrescBits-1:0];
    return row;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // register value: extremes now and then, junk in the bits above the field
  function automatic logic [CfgDataBits-1:0] pick_value(input int unsigned hi);
    logic [CfgDataBits-1:0] v, junk;
    junk = CfgDataBits'($urandom) & ~CfgDataBits'(hi);
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = CfgDataBits'(hi);
      default: v = CfgDataBits'($urandom_range(0, hi));
    endcase
    return v | junk;
  endfunction

  // levels cluster around the base threshold and the raised one
  function automatic logic [SENSOR_BITS-1:0] rand_level(input int base);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = LEVEL_MAX;
      2, 3: v = int'($urandom_range(0, LEVEL_MAX));
      default: v = base + int'($urandom_range(0, RAISE + 4)) - 2;
    endcase
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return v[SENSOR_BITS-1:0];
  endfunction

  // changes cluster around plus and minus the change threshold
  function automatic logic signed [SENSOR_BITS:0] rand_change();
    int v;
    case ($urandom_range(0, 7))
      0: v = CHG_MIN;
      1: v = CHG_MAX;
      2, 3: begin
        v = cfg_chg_thr + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
        if (v > CHG_MAX) v = CHG_MAX;
        if (v < CHG_MIN) v = CHG_MIN;
      end
      default: v = int'($urandom_range(0, CHG_MAX - CHG_MIN)) + CHG_MIN;
    endcase
    return v[SENSOR_BITS:0];
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.ll = rand_level(cfg_left_thr);
    t.rl = rand_level(cfg_right_thr);
    t.lc = rand_change();
    t.rc = rand_change();
    return t;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // channel drivers, each called at a rising edge
  // --------------------------------------------------------------------------

  // payload holds until the transfer, valid stays up when no gap follows
  task automatic offer_tick(input tick_t t, input int unsigned gap,
                            input bit typed, input steer_res_t typed_res);
    steer_res_t res;
    in_valid_i     <= 1'b1;
    left_level_i   <= t.ll;
    right_level_i  <= t.rl;
    left_change_i  <= t.lc;
    right_change_i <= t.rc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transfer at this edge, registers are stable so predict now
    if (typed) steer_due.push_back(typed_res);
    else if (predict_steer(t, res)) steer_due.push_back(res);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_cfg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // idle the block before a register write; disabled ticks leave no
  // expectation behind, so give the pipe its depth after the last result
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (steer_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // output stall pattern, with one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : out_stall_gen
    int unsigned len;
    logic        lvl;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        // long hold-off so the pipe fills and stalls its input
        lvl = 1'b1;
        len = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0: begin lvl = 1'b1; len = $urandom_range(20, 60); end
          1: begin lvl = 1'b0; len = $urandom_range(30, 120); end  // no stalling
          2, 3, 4: begin lvl = 1'b1; len = $urandom_range(1, 3); end
          default: begin lvl = 1'b0; len = $urandom_range(1, 4); end
        endcase
      end
      out_stall_i <= lvl;
      repeat (len) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // result checker: every output transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    steer_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.err = steer_error_o;
      got.lp  = left_prescaler_o;
      got.rp  = right_prescaler_o;
      result_count++;
      if (steer_due.size() == 0) begin
        note_fault($sformatf("result %0d with none due: err %0d lp %0d rp %0d",
                             result_count, $signed(got.err), got.lp, got.rp));
      end else begin
        want = steer_due.pop_front();
        if (got.err !== want.err || got.lp !== want.lp || got.rp !== want.rp) begin
          note_fault($sformatf(
            "result %0d mismatch: expected err %0d lp %0d rp %0d, got err %0d lp %0d rp %0d",
            result_count, $signed(want.err), want.lp, want.rp,
            $signed(got.err), got.lp, got.rp));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    dir_row_t    dir_tab[$];
    int          ph;
    bit          dense;
    bit          squeeze;
    int unsigned wait_cycles;

    // after reset: enable 0, thresholds 0, change threshold 0, bases 0,
    // gain at its default; with change threshold 0 both sides always raise
    dir_tab.push_back(tick_row(LEVEL_MAX, LEVEL_MAX, CHG_MAX, CHG_MIN));     // disabled, no result
    dir_tab.push_back(cfg_row(CFG_STEER_ENABLE, 1));
    dir_tab.push_back(typed_row(0, 0, 0, 0, 0, 0, 0));                      // neither wall
    dir_tab.push_back(typed_row(LEVEL_MAX, LEVEL_MAX, CHG_MAX, CHG_MIN,
                                ERR_MAX, 0, 40));                            // both, largest error
    dir_tab.push_back(typed_row(0, LEVEL_MAX, 0, CHG_MIN, ERR_MAX, 0, 40));  // right only, saturates
    dir_tab.push_back(typed_row(LEVEL_MAX, 0, CHG_MIN, 0, ERR_MIN, 41, 0));  // left only, most negative
    dir_tab.push_back(tick_row(LEVEL_MAX, 0, CHG_MAX, 0));                   // left only
    dir_tab.push_back(tick_row(0, LEVEL_MAX, 0, CHG_MAX));                   // right only
    dir_tab.push_back(tick_row(LEVEL_MAX, LEVEL_MAX, CHG_MIN, CHG_MAX));     // both, negative
    dir_tab.push_back(tick_row(RAISE, RAISE, 100, 50));                      // both tie threshold
    dir_tab.push_back(tick_row(RAISE, 5, 3, 7));                             // left tie, neither
    dir_tab.push_back(tick_row(5, RAISE, 3, 7));                             // right tie, neither
    // change threshold at top, uneven wall thresholds, bases and gain at top
    dir_tab.push_back(cfg_row(CFG_CHANGE_THRESH, LEVEL_MAX));
    dir_tab.push_back(cfg_row(CFG_LEFT_THRESH, LEVEL_MAX));
    dir_tab.push_back(cfg_row(CFG_RIGHT_THRESH, 0));
    dir_tab.push_back(cfg_row(CFG_LEFT_BASE, PRESC_MAX));
    dir_tab.push_back(cfg_row(CFG_RIGHT_BASE, PRESC_MAX));
    dir_tab.push_back(cfg_row(CFG_STEER_GAIN, PRESC_MAX));
    dir_tab.push_back(tick_row(LEVEL_MAX, 0, CHG_MAX - 1, 0));               // just below raise
    dir_tab.push_back(tick_row(LEVEL_MAX, 0, CHG_MAX, 0));                   // raise hides left wall
    dir_tab.push_back(tick_row(LEVEL_MAX, LEVEL_MAX, -CHG_MAX, CHG_MIN));
    dir_tab.push_back(tick_row(0, 0, CHG_MIN, CHG_MAX));
    // zero gain, then a write past the last register that must change nothing
    dir_tab.push_back(cfg_row(CFG_STEER_GAIN, 0));
    dir_tab.push_back(cfg_row(CFG_UNUSED_IDX, PRESC_MAX));
    dir_tab.push_back(tick_row(LEVEL_MAX, LEVEL_MAX, CHG_MAX, CHG_MIN));
    // prescaler clamping at both ends
    dir_tab.push_back(cfg_row(CFG_CHANGE_THRESH, 0));
    dir_tab.push_back(cfg_row(CFG_LEFT_THRESH, 0));
    dir_tab.push_back(cfg_row(CFG_RIGHT_THRESH, LEVEL_MAX));
    dir_tab.push_back(cfg_row(CFG_LEFT_BASE, 0));
    dir_tab.push_back(cfg_row(CFG_STEER_GAIN, PRESC_MAX));
    dir_tab.push_back(tick_row(LEVEL_MAX, LEVEL_MAX, CHG_MAX, CHG_MIN));
    dir_tab.push_back(tick_row(LEVEL_MAX, 0, CHG_MIN, 0));
    // disabled in the middle of the run, then back on
    dir_tab.push_back(cfg_row(CFG_STEER_ENABLE, 0));
    dir_tab.push_back(tick_row(100, 200, 5, -5));
    dir_tab.push_back(cfg_row(CFG_STEER_ENABLE, 1));
    dir_tab.push_back(tick_row(2048, 2048, 0, 0));

    // reset once, released at a rising edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_pipe();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        offer_tick(dir_tab[i].tick, pick_gap(), dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // random phases, each with its own register setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      squeeze = (ph == PRESSURE_PHASE);
      dense   = squeeze || ($urandom_range(0, 3) == 0);
      drain_pipe();
      write_reg(CFG_CHANGE_THRESH, pick_value(ChgThrBits == 12 ? 4095 : (1 << ChgThrBits) - 1));
      write_reg(CFG_LEFT_THRESH, pick_value(LEVEL_MAX));
      write_reg(CFG_RIGHT_THRESH, pick_value(LEVEL_MAX));
      write_reg(CFG_LEFT_BASE, pick_value(PRESC_MAX));
      write_reg(CFG_RIGHT_BASE, pick_value(PRESC_MAX));
      write_reg(CFG_STEER_GAIN, pick_value(PRESC_MAX));
      write_reg(CFG_STEER_ENABLE,
                {CfgDataBits'($urandom) & ~CfgDataBits'(1)} |
                CfgDataBits'(squeeze || ($urandom_range(0, 5) != 0)));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_IDX, CfgDataBits'($urandom));
      if (squeeze) begin
        // wait for the stall process to take up the hold-off, then flood
        hold_off_req = 1'b1;
        while (hold_off_req) @(posedge clk_i);
      end
      repeat (TICKS_PER_PHASE) offer_tick(rand_tick(), dense ? 0 : pick_gap(), 1'b0, '0);
    end

    // let the last results come out, then look for leftovers
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (steer_due.size() != 0 && wait_cycles < FINAL_WAIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (steer_due.size() != 0)
      note_fault($sformatf("%0d predicted results never arrived", steer_due.size()));

    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard limit on run length
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
